// File: sv/pmts_pkg.sv
// Shared types, constants and helper functions for the pointer-motion-to-scroll block.
package pmts_pkg;

  // Timing and scale constants
  localparam int FLUSH_MS        = 20;
  localparam int IDLE_MS         = 300;
  localparam int EARLY_MS        = 1000;
  localparam int RATE_ONE        = 1024;
  localparam int RATE_SHIFT      = 10;
  localparam int POINT_SCALE_DEF = 1;
  localparam int FIXED_SCALE_DEF = 65536;
  localparam int RATE_RESET      = 1024;

  // State widths
  localparam int ACC_W   = 24;
  localparam int FLUSH_W = 5;
  localparam int IDLE_W  = 9;
  localparam int AGE_W   = 10;
  localparam int RATE_W  = 14;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 14;

  // Shared multiplier: A is split into two halves, one partial product per cycle
  localparam int MUL_A_W    = 40;
  localparam int MUL_HALF_W = MUL_A_W / 2;
  localparam int MUL_B_W    = 17;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int WQ_W       = MUL_A_W - RATE_SHIFT;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DIS_V  = 2'd0,
    REG_DIS_H  = 2'd1,
    REG_FIX_EN = 2'd2,
    REG_RATE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_RATE  = 2'd0,
    OP_FIXED = 2'd1,
    OP_POINT = 2'd2
  } op_t;

  typedef struct packed {
    logic               action;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic               drag_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] wheel_vertical;
    logic signed [15:0] wheel_horizontal;
    logic signed [31:0] fixed_vertical;
    logic signed [31:0] fixed_horizontal;
    logic signed [31:0] point_vertical;
    logic signed [31:0] point_horizontal;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Signed 32-bit result from a magnitude and a sign, saturated
  function automatic logic [31:0] sat32(input logic [MUL_P_W-1:0] m, input logic neg);
    logic [MUL_P_W-1:0] lim;
    logic [31:0]        c;
    lim = neg ? MUL_P_W'(33'h080000000) : MUL_P_W'(33'h07FFFFFFF);
    c   = (m > lim) ? lim[31:0] : m[31:0];
    return neg ? (~c + 32'd1) : c;
  endfunction

  // Wheel delta: saturated to 16 bits, at least magnitude one for a nonzero delta
  function automatic logic [15:0] wheel_fmt(input logic [WQ_W-1:0] q, input logic neg,
                                            input logic nz);
    logic [WQ_W-1:0] lim;
    logic [15:0]     c;
    lim = neg ? WQ_W'(32768) : WQ_W'(32767);
    c   = (q > lim) ? lim[15:0] : q[15:0];
    if (nz && (c == 16'd0)) c = 16'd1;
    return neg ? (~c + 16'd1) : c;
  endfunction

endpackage

// File: sv/pmts_mul.sv
// Shared unsigned multiplier: one half-width partial product per cycle, accumulated.
module pmts_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pmts_pkg::MUL_A_W-1:0]   a,
  input  logic [pmts_pkg::MUL_B_W-1:0]   b,
  output pmts_pkg::mul_stat_t            stat,
  output logic [pmts_pkg::MUL_P_W-1:0]   prod
);

  localparam int AW = pmts_pkg::MUL_A_W;
  localparam int HW = pmts_pkg::MUL_HALF_W;
  localparam int BW = pmts_pkg::MUL_B_W;
  localparam int PW = pmts_pkg::MUL_P_W;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_LO   = 3'b010,
    M_HI   = 3'b100
  } mstate_t;

  mstate_t           state_r, state_nxt;
  logic              done_r, done_nxt;
  logic [AW-1:0]     a_r, a_nxt;
  logic [BW-1:0]     b_r, b_nxt;
  logic [PW-1:0]     prod_r, prod_nxt;
  logic [HW-1:0]     half;
  logic [HW+BW-1:0]  pp;

  assign half = (state_r == M_HI) ? a_r[AW-1:HW] : a_r[HW-1:0];
  assign pp   = half * b_r;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    a_nxt     = a_r;
    b_nxt     = b_r;
    prod_nxt  = prod_r;
    case (state_r)
      M_IDLE: begin
        if (start) begin
          a_nxt     = a;
          b_nxt     = b;
          state_nxt = M_LO;
        end
      end
      M_LO: begin
        prod_nxt  = PW'(pp);
        state_nxt = M_HI;
      end
      M_HI: begin
        prod_nxt  = prod_r + {pp, {HW{1'b0}}};
        done_nxt  = 1'b1;
        state_nxt = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
  end

  assign stat.busy = (state_r != M_IDLE);
  assign stat.done = done_r;
  assign prod      = prod_r;

endmodule

// File: sv/pointer_motion_to_scroll.sv
// Top level: motion accumulation, flush, axis suppression, fixation and scaling sequencer.
//
// Input channel (in_valid / in_stall / in_data): each item is a 1 ms tick or a pointer
// motion. An item is taken when in_valid is high and in_stall is low.
// Ticks and motions that do not flush leave the sequencer idle; in_stall stays low.
// A flushing motion runs the sequencer: magnitude, dominance and fixation work, then six
// passes through the shared two-half multiplier (rate, fixed and point for each axis).
// A flush that leaves both axes zero gives no result.
// Result channel (out_valid / out_stall / out_data): a one-deep output register. While
// the receiver stalls, the result holds and ticks and non-flushing motions are still
// taken; a second result waits inside the block with in_stall high.
// Configuration (cfg_we / cfg_addr / cfg_wdata): the user must write it only while the block is idle;
// the block does not enforce this. Reset (rst_n low, synchronous): accumulators and fixation sums clear,
// the timers start saturated, scroll rate returns to 1024 and the disables to zero.
module pointer_motion_to_scroll #(
  parameter int POINT_SCALE = pmts_pkg::POINT_SCALE_DEF,
  parameter int FIXED_SCALE = pmts_pkg::FIXED_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pmts_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pmts_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [pmts_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pmts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW   = pmts_pkg::ACC_W;
  localparam int FW   = pmts_pkg::FLUSH_W;
  localparam int IW   = pmts_pkg::IDLE_W;
  localparam int GW   = pmts_pkg::AGE_W;
  localparam int RW   = pmts_pkg::RATE_W;
  localparam int MAW  = pmts_pkg::MUL_A_W;
  localparam int MBW  = pmts_pkg::MUL_B_W;
  localparam int MPW  = pmts_pkg::MUL_P_W;
  localparam int SH   = pmts_pkg::RATE_SHIFT;
  localparam int FIX_MUL = FIXED_SCALE / pmts_pkg::RATE_ONE;
  localparam logic [MBW-1:0] FIX_B = MBW'(FIX_MUL);
  localparam logic [MBW-1:0] PNT_B = MBW'(POINT_SCALE);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MAG  = 6'b000010,
    S_DOM  = 6'b000100,
    S_FIX  = 6'b001000,
    S_MUL  = 6'b010000,
    S_LOAD = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   dis_v_r, dis_v_nxt, dis_h_r, dis_h_nxt, fix_en_r, fix_en_nxt;
  logic [RW-1:0]          rate_r, rate_nxt;
  logic signed [AW-1:0]   accum_v_r, accum_v_nxt, accum_h_r, accum_h_nxt;
  logic [FW-1:0]          flush_timer_r, flush_timer_nxt;
  logic [IW-1:0]          idle_timer_r, idle_timer_nxt;
  logic [GW-1:0]          age_r, age_nxt;
  logic [AW-1:0]          fsum_v_r, fsum_v_nxt, fsum_h_r, fsum_h_nxt;
  logic signed [AW-1:0]   dv_r, dv_nxt, dh_r, dh_nxt;
  logic [AW-1:0]          av_r, av_nxt, ah_r, ah_nxt;
  pmts_pkg::op_t          op_r, op_nxt;
  logic                   axis_r, axis_nxt;
  logic                   start_r, start_nxt;
  logic [MAW-1:0]         m1_r, m1_nxt;
  pmts_pkg::out_item_t    res_r, res_nxt;
  pmts_pkg::out_item_t    out_data_r, out_data_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   in_acc;
  logic signed [AW-1:0]   acc_v_new, acc_h_new;
  logic signed [AW-1:0]   dv_lock, dh_lock;
  logic signed [AW-1:0]   cur_d;
  logic [AW-1:0]          cur_mag;
  logic                   cur_neg, cur_nz;
  logic [MAW-1:0]         mul_a;
  logic [MBW-1:0]         mul_b;
  logic [MPW-1:0]         mul_prod;
  pmts_pkg::mul_stat_t    mul_stat;
  logic [15:0]            wheel_val;
  logic [31:0]            fixed_val, point_val;

  function automatic logic signed [AW-1:0] acc_step(input logic signed [AW-1:0] base,
                                                    input logic signed [15:0] mv);
    logic signed [AW:0] s;
    s = {base[AW-1], base} - {{(AW-15){mv[15]}}, mv};
    if (s[AW] != s[AW-1]) return s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] abs_d(input logic signed [AW-1:0] v);
    return v[AW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] x, input logic [AW-1:0] y);
    logic [AW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[AW] ? {AW{1'b1}} : s[AW-1:0];
  endfunction

  assign in_stall = !(state_r == S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign acc_v_new = acc_step(in_data.drag_start ? '0 : accum_v_r, in_data.move_y);
  assign acc_h_new = acc_step(in_data.drag_start ? '0 : accum_h_r, in_data.move_x);

  // Fixation lock from the running sums
  assign dh_lock = (fix_en_r && ({1'b0, fsum_v_r} > {fsum_h_r, 1'b0})) ? '0 : dh_r;
  assign dv_lock = (fix_en_r && ({1'b0, fsum_h_r} > {fsum_v_r, 1'b0})) ? '0 : dv_r;

  // Operands for the shared multiplier
  assign cur_d   = axis_r ? dh_r : dv_r;
  assign cur_neg = cur_d[AW-1];
  assign cur_nz  = (cur_d != '0);
  assign cur_mag = abs_d(cur_d);
  assign mul_a   = (op_r == pmts_pkg::OP_RATE) ? MAW'(cur_mag) : m1_r;
  assign mul_b   = (op_r == pmts_pkg::OP_RATE)  ? MBW'(rate_r) :
                   (op_r == pmts_pkg::OP_FIXED) ? FIX_B : PNT_B;

  assign wheel_val = pmts_pkg::wheel_fmt(mul_prod[MAW-1:SH], cur_neg, cur_nz);
  assign fixed_val = pmts_pkg::sat32(mul_prod, cur_neg);
  assign point_val = pmts_pkg::sat32(mul_prod >> SH, cur_neg);

  pmts_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  always_comb begin
    state_nxt       = state_r;
    dis_v_nxt       = dis_v_r;
    dis_h_nxt       = dis_h_r;
    fix_en_nxt      = fix_en_r;
    rate_nxt        = rate_r;
    accum_v_nxt     = accum_v_r;
    accum_h_nxt     = accum_h_r;
    flush_timer_nxt = flush_timer_r;
    idle_timer_nxt  = idle_timer_r;
    age_nxt         = age_r;
    fsum_v_nxt      = fsum_v_r;
    fsum_h_nxt      = fsum_h_r;
    dv_nxt          = dv_r;
    dh_nxt          = dh_r;
    av_nxt          = av_r;
    ah_nxt          = ah_r;
    op_nxt          = op_r;
    axis_nxt        = axis_r;
    start_nxt       = 1'b0;
    m1_nxt          = m1_r;
    res_nxt         = res_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r;

    if (cfg_we) begin
      case (pmts_pkg::cfg_reg_t'(cfg_addr))
        pmts_pkg::REG_DIS_V:  dis_v_nxt  = cfg_wdata[0];
        pmts_pkg::REG_DIS_H:  dis_h_nxt  = cfg_wdata[0];
        pmts_pkg::REG_FIX_EN: fix_en_nxt = cfg_wdata[0];
        pmts_pkg::REG_RATE:   rate_nxt   = cfg_wdata[RW-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_data.action) begin
            if (flush_timer_r < FW'(pmts_pkg::FLUSH_MS)) flush_timer_nxt = flush_timer_r + 1'b1;
            if (idle_timer_r < IW'(pmts_pkg::IDLE_MS + 1)) idle_timer_nxt = idle_timer_r + 1'b1;
            if (age_r < GW'(pmts_pkg::EARLY_MS)) age_nxt = age_r + 1'b1;
          end else if (flush_timer_r < FW'(pmts_pkg::FLUSH_MS)) begin
            accum_v_nxt = acc_v_new;
            accum_h_nxt = acc_h_new;
          end else begin
            accum_v_nxt     = '0;
            accum_h_nxt     = '0;
            flush_timer_nxt = '0;
            dv_nxt          = dis_v_r ? '0 : acc_v_new;
            dh_nxt          = dis_h_r ? '0 : acc_h_new;
            state_nxt       = S_MAG;
          end
        end
      end
      S_MAG: begin
        av_nxt    = abs_d(dv_r);
        ah_nxt    = abs_d(dh_r);
        state_nxt = S_DOM;
      end
      S_DOM: begin
        if ({1'b0, av_r} > {ah_r, 1'b0}) dh_nxt = '0;
        if ({1'b0, ah_r} > {av_r, 1'b0}) dv_nxt = '0;
        if (fix_en_r) begin
          // long idle restarts fixation
          if (idle_timer_r > IW'(pmts_pkg::IDLE_MS)) begin
            age_nxt    = '0;
            fsum_v_nxt = '0;
            fsum_h_nxt = '0;
          end
          idle_timer_nxt = '0;
        end
        state_nxt = S_FIX;
      end
      S_FIX: begin
        // sums grow from the pre-dominance magnitudes
        if (fix_en_r && (age_r < GW'(pmts_pkg::EARLY_MS))) begin
          if (dv_lock == '0) fsum_h_nxt = sat_add(fsum_h_r, ah_r);
          if (dh_lock == '0) fsum_v_nxt = sat_add(fsum_v_r, av_r);
        end
        dv_nxt = dv_lock;
        dh_nxt = dh_lock;
        if ((dv_lock == '0) && (dh_lock == '0)) begin
          state_nxt = S_IDLE;
        end else begin
          axis_nxt  = 1'b0;
          op_nxt    = pmts_pkg::OP_RATE;
          start_nxt = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          case (op_r)
            pmts_pkg::OP_RATE: begin
              m1_nxt = mul_prod[MAW-1:0];
              if (axis_r) res_nxt.wheel_horizontal = wheel_val;
              else        res_nxt.wheel_vertical   = wheel_val;
              op_nxt    = pmts_pkg::OP_FIXED;
              start_nxt = 1'b1;
            end
            pmts_pkg::OP_FIXED: begin
              if (axis_r) res_nxt.fixed_horizontal = fixed_val;
              else        res_nxt.fixed_vertical   = fixed_val;
              op_nxt    = pmts_pkg::OP_POINT;
              start_nxt = 1'b1;
            end
            pmts_pkg::OP_POINT: begin
              if (axis_r) begin
                res_nxt.point_horizontal = point_val;
                state_nxt = S_LOAD;
              end else begin
                res_nxt.point_vertical = point_val;
                axis_nxt  = 1'b1;
                op_nxt    = pmts_pkg::OP_RATE;
                start_nxt = 1'b1;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      dis_v_r       <= 1'b0;
      dis_h_r       <= 1'b0;
      fix_en_r      <= 1'b0;
      rate_r        <= RW'(pmts_pkg::RATE_RESET);
      accum_v_r     <= '0;
      accum_h_r     <= '0;
      flush_timer_r <= FW'(pmts_pkg::FLUSH_MS);
      idle_timer_r  <= IW'(pmts_pkg::IDLE_MS + 1);
      age_r         <= GW'(pmts_pkg::EARLY_MS);
      fsum_v_r      <= '0;
      fsum_h_r      <= '0;
      op_r          <= pmts_pkg::OP_RATE;
      axis_r        <= 1'b0;
      start_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      dis_v_r       <= dis_v_nxt;
      dis_h_r       <= dis_h_nxt;
      fix_en_r      <= fix_en_nxt;
      rate_r        <= rate_nxt;
      accum_v_r     <= accum_v_nxt;
      accum_h_r     <= accum_h_nxt;
      flush_timer_r <= flush_timer_nxt;
      idle_timer_r  <= idle_timer_nxt;
      age_r         <= age_nxt;
      fsum_v_r      <= fsum_v_nxt;
      fsum_h_r      <= fsum_h_nxt;
      op_r          <= op_nxt;
      axis_r        <= axis_nxt;
      start_r       <= start_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dv_r       <= dv_nxt;
    dh_r       <= dh_nxt;
    av_r       <= av_nxt;
    ah_r       <= ah_nxt;
    m1_r       <= m1_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_start_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (state_r == S_MUL && !mul_stat.busy))
    else $error("multiplier started outside the multiply phase or while busy");

  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == S_MUL))
    else $error("multiplier finished with no sequencer waiting");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAG) |-> (flush_timer_r == '0 && accum_v_r == '0 && accum_h_r == '0))
    else $error("flush did not clear accumulators and flush timer");

  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (dv_r != '0 || dh_r != '0))
    else $error("result produced with both axes zero");

  a_timer_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_timer_r <= FW'(pmts_pkg::FLUSH_MS)) &&
    (idle_timer_r <= IW'(pmts_pkg::IDLE_MS + 1)) &&
    (age_r <= GW'(pmts_pkg::EARLY_MS)))
    else $error("timer beyond its saturation value");
`endif

endmodule

// File: dv/tb.sv
// Self-checking testbench for pointer_motion_to_scroll: directed and random items, predictor.
`timescale 1ns / 100ps

module tb;

  localparam int POINT_SCALE = 1;
  localparam int FIXED_SCALE = 65536;
  localparam int FLUSH_TICKS = 20;
  localparam int IDLE_TICKS = 300;
  localparam int EARLY_TICKS = 1000;
  localparam int RATE_UNIT = 1024;
  localparam int MAX_WAIT = 11;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;

  localparam longint ACC_HI = 64'sd8388607;
  localparam longint ACC_LO = -64'sd8388608;
  localparam longint SUM_HI = 64'sd16777215;
  localparam longint WHEEL_HI = 64'sd32767;
  localparam longint WHEEL_LO = -64'sd32768;
  localparam longint I32_HI = 64'sd2147483647;
  localparam longint I32_LO = -64'sd2147483648;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_MOTION = 1'b1;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pmts_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  pmts_pkg::out_item_t out_data;
  logic cfg_we;
  logic [pmts_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [pmts_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // mirror of the block's configuration and state
  logic dis_v, dis_h, fix_en;
  logic [pmts_pkg::RATE_W-1:0] rate;
  logic signed [pmts_pkg::ACC_W-1:0] mv_v, mv_h;
  logic [pmts_pkg::FLUSH_W-1:0] since_flush;
  logic [pmts_pkg::IDLE_W-1:0] since_fix;
  logic [pmts_pkg::AGE_W-1:0] fix_age;
  logic [pmts_pkg::ACC_W-1:0] lock_v, lock_h;

  pmts_pkg::out_item_t pending_scrolls[$];
  int error_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int in_gap_max = MAX_WAIT;
  int out_gap_max = MAX_WAIT;
  int hold_left = 0;
  bit hold_due = 1'b1;

  pointer_motion_to_scroll #(
    .POINT_SCALE(POINT_SCALE),
    .FIXED_SCALE(FIXED_SCALE)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void scale_delta(input longint d, output logic signed [15:0] w,
                                      output logic signed [31:0] f,
                                      output logic signed [31:0] p);
    longint prod, q;
    prod = d * longint'(rate);
    q = clip(prod / RATE_UNIT, WHEEL_LO, WHEEL_HI);
    if (q == 0 && d != 0) q = (d > 0) ? 1 : -1;
    w = 16'(q);
    f = 32'(clip(prod * (FIXED_SCALE / RATE_UNIT), I32_LO, I32_HI));
    p = 32'(clip((d * POINT_SCALE * longint'(rate)) / RATE_UNIT, I32_LO, I32_HI));
  endfunction

  task automatic predict_scroll(input pmts_pkg::in_item_t it);
    longint dv, dh, av, ah;
    pmts_pkg::out_item_t r;
    if (it.action == ACT_TICK) begin
      if (since_flush < FLUSH_TICKS) since_flush++;
      if (since_fix < IDLE_TICKS + 1) since_fix++;
      if (fix_age < EARLY_TICKS) fix_age++;
      return;
    end
    if (it.drag_start) begin
      mv_v = '0;
      mv_h = '0;
    end
    // accumulators hold the negated motion
    mv_v = pmts_pkg::ACC_W'(clip(longint'(mv_v) - longint'(it.move_y), ACC_LO, ACC_HI));
    mv_h = pmts_pkg::ACC_W'(clip(longint'(mv_h) - longint'(it.move_x), ACC_LO, ACC_HI));
    if (since_flush < FLUSH_TICKS) return;

    dv = mv_v;
    dh = mv_h;
    mv_v = '0;
    mv_h = '0;
    since_flush = '0;
    if (dis_v) dv = 0;
    if (dis_h) dh = 0;
    av = (dv < 0) ? -dv : dv;
    ah = (dh < 0) ? -dh : dh;
    if (av > 2 * ah) dh = 0;
    if (ah > 2 * av) dv = 0;

    if (fix_en) begin
      if (since_fix > IDLE_TICKS) begin
        fix_age = '0;
        lock_v = '0;
        lock_h = '0;
      end
      since_fix = '0;
      if (longint'(lock_v) > 2 * longint'(lock_h)) dh = 0;
      if (longint'(lock_h) > 2 * longint'(lock_v)) dv = 0;
      // sums use the magnitudes from before suppression
      if (fix_age < EARLY_TICKS) begin
        if (dv == 0) lock_h = pmts_pkg::ACC_W'(clip(longint'(lock_h) + ah, 0, SUM_HI));
        if (dh == 0) lock_v = pmts_pkg::ACC_W'(clip(longint'(lock_v) + av, 0, SUM_HI));
      end
    end

    if (dv == 0 && dh == 0) return;
    scale_delta(dv, r.wheel_vertical, r.fixed_vertical, r.point_vertical);
    scale_delta(dh, r.wheel_horizontal, r.fixed_horizontal, r.point_horizontal);
    pending_scrolls.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    pmts_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      hold_due = 1'b1;
      if (pending_scrolls.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_scrolls.pop_front();
        compare_field("wheel_vertical", want.wheel_vertical, out_data.wheel_vertical);
        compare_field("wheel_horizontal", want.wheel_horizontal, out_data.wheel_horizontal);
        compare_field("fixed_vertical", want.fixed_vertical, out_data.fixed_vertical);
        compare_field("fixed_horizontal", want.fixed_horizontal, out_data.fixed_horizontal);
        compare_field("point_vertical", want.point_vertical, out_data.point_vertical);
        compare_field("point_horizontal", want.point_horizontal, out_data.point_horizontal);
      end
    end
  end

  // receiver: a fresh hold count per result, random stall while nothing is offered
  always @(negedge clk) begin
    if (out_valid && hold_due) begin
      hold_left = (out_gap_max > 0) ? $urandom_range(0, out_gap_max) : 0;
      hold_due = 1'b0;
    end
    if (out_valid) begin
      out_stall <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end else begin
      out_stall <= (out_gap_max > 0) && ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // starts and ends at a falling edge; valid stays high for a back-to-back item
  task automatic deliver_item(input pmts_pkg::in_item_t it);
    int gap;
    gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_scroll(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    pmts_pkg::in_item_t it;
    repeat (n) begin
      it.action = ACT_TICK;
      it.move_x = 16'($urandom);
      it.move_y = 16'($urandom);
      it.drag_start = 1'($urandom);
      deliver_item(it);
    end
  endtask

  function automatic pmts_pkg::in_item_t make_motion(input logic signed [15:0] dx,
                                                     input logic signed [15:0] dy,
                                                     input logic drag);
    pmts_pkg::in_item_t it;
    it.action = ACT_MOTION;
    it.move_x = dx;
    it.move_y = dy;
    it.drag_start = drag;
    return it;
  endfunction

  function automatic logic signed [15:0] rand_delta();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'(int'($urandom_range(0, 16)) - 8);
      2: return 16'(int'($urandom_range(0, 600)) - 300);
      3: return 16'($urandom);
      4: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [pmts_pkg::RATE_W-1:0] rand_rate();
    case ($urandom_range(0, 3))
      0: return pmts_pkg::RATE_W'(RATE_UNIT);
      1: return pmts_pkg::RATE_W'($urandom_range(0, (1 << pmts_pkg::RATE_W) - 1));
      2: return pmts_pkg::RATE_W'($urandom_range(1, 64));
      default: return pmts_pkg::RATE_W'($urandom_range(512, 4096));
    endcase
  endfunction

  // block must be idle; writes all four registers on consecutive cycles
  task automatic apply_config(input logic v_off, input logic h_off, input logic fix_on,
                              input logic [pmts_pkg::RATE_W-1:0] r);
    pmts_pkg::cfg_reg_t idx;
    idx = idx.first();
    cfg_we <= 1'b1;
    repeat (idx.num()) begin
      cfg_addr <= idx;
      case (idx)
        pmts_pkg::REG_DIS_V:  cfg_wdata <= pmts_pkg::CFG_DATA_W'(v_off);
        pmts_pkg::REG_DIS_H:  cfg_wdata <= pmts_pkg::CFG_DATA_W'(h_off);
        pmts_pkg::REG_FIX_EN: cfg_wdata <= pmts_pkg::CFG_DATA_W'(fix_on);
        pmts_pkg::REG_RATE:   cfg_wdata <= pmts_pkg::CFG_DATA_W'(r);
        default:              cfg_wdata <= '0;
      endcase
      @(negedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    dis_v = v_off;
    dis_h = h_off;
    fix_en = fix_on;
    rate = r;
  endtask

  // a flush with both axes zero gives nothing back, so wait on after the queue empties
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_scrolls.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly enough ticks for a flush, then a few motions; sometimes too few ticks
  task automatic scroll_burst();
    int ticks;
    in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
    out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
    if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, FLUSH_TICKS - 1);
    else ticks = $urandom_range(FLUSH_TICKS, FLUSH_TICKS + 4);
    send_ticks(ticks);
    repeat ($urandom_range(1, 3))
      deliver_item(make_motion(rand_delta(), rand_delta(), $urandom_range(0, 5) == 0));
  endtask

  task automatic run_bursts(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) scroll_burst();
  endtask

  task automatic test_directed();
    apply_config(1'b0, 1'b0, 1'b1, pmts_pkg::RATE_W'(RATE_UNIT));
    // flush is due out of reset; full-scale deltas saturate the wheel
    deliver_item(make_motion(16'sh7fff, 16'sh8000, 1'b0));
    // not due yet: piles up, then drag start drops it
    deliver_item(make_motion(16'sh8000, 16'sh7fff, 1'b0));
    deliver_item(make_motion(16'sh0000, 16'shffff, 1'b1));
    settle();
    apply_config(1'b0, 1'b0, 1'b1, '0);
    send_ticks(FLUSH_TICKS);
    deliver_item(make_motion('0, '0, 1'b0));
  endtask

  task automatic test_fixation_lock();
    int late_bursts, next_retune;
    late_bursts = 0;
    settle();
    apply_config(1'b0, 1'b0, 1'b1, pmts_pkg::RATE_W'(RATE_UNIT));
    next_retune = items_sent + 300;
    // run through the early window and a little past it
    while (late_bursts < 5) begin
      if (items_sent >= next_retune) begin
        settle();
        apply_config($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, 1'b1, rand_rate());
        next_retune = items_sent + 300;
      end
      scroll_burst();
      if (fix_age >= EARLY_TICKS) late_bursts++;
    end
  endtask

  task automatic test_rate_and_disables();
    settle();
    apply_config(1'b1, 1'b0, 1'b0, pmts_pkg::RATE_W'(RATE_UNIT));
    run_bursts(20);
    settle();
    apply_config(1'b0, 1'b1, 1'b0, rand_rate());
    run_bursts(20);
    settle();
    apply_config(1'b1, 1'b1, 1'b0, rand_rate());
    run_bursts(20);
    settle();
    apply_config(1'b0, 1'b0, 1'b0, '0);
    run_bursts(20);
    settle();
    apply_config(1'b0, 1'b0, 1'b0, '1);
    run_bursts(20);
    settle();
    apply_config(1'b0, 1'b0, 1'b0, rand_rate());
    run_bursts(20);
  endtask

  task automatic test_accum_saturation();
    settle();
    apply_config(1'b0, 1'b0, 1'b0, '1);
    send_ticks(FLUSH_TICKS);
    deliver_item(make_motion('0, '0, 1'b1));
    // enough full-scale motion to pin both accumulators
    repeat (260) deliver_item(make_motion(16'sh7fff, 16'sh8000, 1'b0));
    send_ticks(FLUSH_TICKS);
    deliver_item(make_motion(16'sh7fff, 16'sh8000, 1'b0));
  endtask

  task automatic test_idle_restart();
    settle();
    apply_config(1'b0, 1'b0, 1'b1, rand_rate());
    // top up idle time so the next flush restarts fixation
    if (since_fix <= IDLE_TICKS) send_ticks(IDLE_TICKS + 1 - int'(since_fix));
    run_bursts(120);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    dis_v = 1'b0;
    dis_h = 1'b0;
    fix_en = 1'b0;
    rate = pmts_pkg::RATE_W'(RATE_UNIT);
    mv_v = '0;
    mv_h = '0;
    since_flush = pmts_pkg::FLUSH_W'(FLUSH_TICKS);
    since_fix = pmts_pkg::IDLE_W'(IDLE_TICKS + 1);
    fix_age = pmts_pkg::AGE_W'(EARLY_TICKS);
    lock_v = '0;
    lock_h = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fixation_lock();
    test_rate_and_disables();
    test_accum_saturation();
    test_idle_restart();
    settle();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/pmts_pkg.sv
sv/pmts_mul.sv
sv/pointer_motion_to_scroll.sv
dv/tb.sv
